FILE: hdl/assert_macros.svh
// assertion macros shared by the pixel queue mixer rtl
// no dependencies; included by the modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define PFSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define PFSM_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/pfsm_pkg.sv
// shared types, operation codes and constants for the pixel queue mixer
// no dependencies; used by every module of the block
package pfsm_pkg;

    // operation codes carried in the input word
    localparam logic [2:0] FUNC_CLEAR_ALL = 3'd0;
    localparam logic [2:0] FUNC_CLEAR_BG  = 3'd1;
    localparam logic [2:0] FUNC_PUSH      = 3'd2;
    localparam logic [2:0] FUNC_DISCARD   = 3'd3;
    localparam logic [2:0] FUNC_MIX       = 3'd4;
    localparam logic [2:0] FUNC_POP       = 3'd5;

    // pixel source codes
    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_BG   = 2'd1;
    localparam logic [1:0] SRC_OBJ  = 2'd2;

    // register indexes on the config port
    localparam logic [1:0] REG_COLOR_MODE = 2'd0;
    localparam logic [1:0] REG_BG_ENABLE  = 2'd1;
    localparam logic [1:0] REG_SPRITE_EN  = 2'd2;

    // queue geometry and attribute bits
    localparam int          QDEPTH        = 8;
    localparam logic [3:0]  QFULL         = 4'd8;
    localparam logic [5:0]  EMPTY_RANK    = 6'd60;
    localparam int          ATTR_PRIO_BIT = 7;
    localparam int          ATTR_FLIP_BIT = 5;
    localparam int          ATTR_OPAL_BIT = 4;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] plane_low;
        logic [7:0] plane_high;
        logic [7:0] attr;
        logic [5:0] sprite_index;
        logic [2:0] discard_count;
    } item_t;

    typedef struct packed {
        logic       pixel_valid;
        logic [1:0] source;
        logic [1:0] color_index;
        logic [2:0] palette_number;
        logic       push_accepted;
        logic [3:0] bg_level;
        logic [3:0] obj_level;
    } result_t;

    typedef struct packed {
        logic color_mode;
        logic bg_enable;
        logic sprite_en;
    } cfg_t;

    typedef struct packed {
        logic       prio;
        logic [2:0] pal;
        logic [1:0] color;
    } bg_entry_t;

    typedef struct packed {
        logic [5:0] rank;
        logic       prio;
        logic [2:0] pal;
        logic [1:0] color;
    } obj_entry_t;

    localparam int BG_ENTRY_W = $bits(bg_entry_t);

endpackage

FILE: hdl/pixel_fifo_sprite_mixer_core.sv
// channel   | dir | handshake                | payload
// s_axis    | in  | s_axis_tvalid/tready     | tuser: func; tdata: pixel rows and controls
// m_axis    | out | m_axis_tvalid/tready     | tdata: pixel result and queue levels
// apb       | in  | psel/penable/pwrite      | paddr, pwdata, prdata (mode bits)
//
// one word in and one word out per cycle while m_axis takes results: an input register feeds the queue
// update and priority logic, which lands in the result register
// an accepted word waits in the input register, and its result in the result register
// rst_n clears the handshake state and both queue levels and resets the mode bits
// a stalled m_axis holds the result; the input register keeps taking a word
// whenever the result register frees in the same cycle
//
// top level of the pixel queue mixer; depends on pfsm_pkg, pfsm_cfg_regs,
// pfsm_bg_queue, pfsm_obj_queue and assert_macros.svh
`include "assert_macros.svh"

module pixel_fifo_sprite_mixer_core
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // plane_low[7:0], plane_high[15:8], attr[23:16], sprite_index[29:24],
    // discard_count[32:30], zero fill [39:33]
    input  logic [39:0] s_axis_tdata,
    // func[2:0]
    input  logic [2:0]  s_axis_tuser,
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_valid[0], source[2:1], color_index[4:3], palette_number[7:5],
    // push_accepted[8], bg_level[12:9], obj_level[16:13], zero fill [23:17]
    output logic [23:0] m_axis_tdata,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pfsm_pkg::cfg_t       cfg;
    pfsm_pkg::item_t      item_in;
    pfsm_pkg::item_t      item_reg;
    logic                 in_valid_reg;
    logic                 in_valid_next;
    pfsm_pkg::result_t    result_reg;
    pfsm_pkg::result_t    result_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 fire;
    logic                 accept;
    pfsm_pkg::bg_entry_t  bg_head;
    pfsm_pkg::obj_entry_t obj_head;
    logic                 bg_nonempty;
    logic                 obj_nonempty;
    logic                 push_ok;
    logic [3:0]           bg_level_next;
    logic [3:0]           obj_level_next;
    logic                 has_bg;
    logic                 has_sp;
    logic [1:0]           pick;

    // stage control
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;

    // unpack the input word
    assign item_in.func          = s_axis_tuser;
    assign item_in.plane_low     = s_axis_tdata[7:0];
    assign item_in.plane_high    = s_axis_tdata[15:8];
    assign item_in.attr          = s_axis_tdata[23:16];
    assign item_in.sprite_index  = s_axis_tdata[29:24];
    assign item_in.discard_count = s_axis_tdata[32:30];

    assign in_valid_next  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    pfsm_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pfsm_bg_queue u_bg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (item_reg),
        .cfg        (cfg),
        .head       (bg_head),
        .nonempty   (bg_nonempty),
        .push_ok    (push_ok),
        .level_next (bg_level_next)
    );

    pfsm_obj_queue u_obj
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (item_reg),
        .cfg        (cfg),
        .pop_en     (bg_nonempty),
        .head       (obj_head),
        .nonempty   (obj_nonempty),
        .level_next (obj_level_next)
    );

    // background versus object priority at pop
    assign has_bg = cfg.color_mode || cfg.bg_enable;
    assign has_sp = cfg.sprite_en && obj_nonempty;

    always_comb
    begin
        if (has_bg && !has_sp)
        begin
            pick = pfsm_pkg::SRC_BG;
        end
        else if (!has_bg && has_sp)
        begin
            pick = pfsm_pkg::SRC_OBJ;
        end
        else if (has_bg && has_sp)
        begin
            if (cfg.color_mode)
            begin
                if (obj_head.color == 2'd0)
                    pick = pfsm_pkg::SRC_BG;
                else if (!cfg.bg_enable)
                    pick = pfsm_pkg::SRC_OBJ;
                else if (!obj_head.prio && !bg_head.prio)
                    pick = pfsm_pkg::SRC_OBJ;
                else if (bg_head.color != 2'd0)
                    pick = pfsm_pkg::SRC_BG;
                else
                    pick = pfsm_pkg::SRC_OBJ;
            end
            else
            begin
                if (obj_head.prio && (bg_head.color != 2'd0))
                    pick = pfsm_pkg::SRC_BG;
                else if (obj_head.color == 2'd0)
                    pick = pfsm_pkg::SRC_BG;
                else
                    pick = pfsm_pkg::SRC_OBJ;
            end
        end
        else
        begin
            pick = pfsm_pkg::SRC_NONE;
        end
    end

    // result word
    always_comb
    begin
        result_next               = '0;
        result_next.push_accepted = push_ok;
        result_next.bg_level      = bg_level_next;
        result_next.obj_level     = obj_level_next;
        if ((item_reg.func == pfsm_pkg::FUNC_POP) && bg_nonempty)
        begin
            result_next.pixel_valid = 1'b1;
            result_next.source      = pick;
            case (pick)
                pfsm_pkg::SRC_BG:
                begin
                    result_next.color_index    = bg_head.color;
                    result_next.palette_number = cfg.color_mode ? bg_head.pal : 3'd0;
                end
                pfsm_pkg::SRC_OBJ:
                begin
                    result_next.color_index    = obj_head.color;
                    result_next.palette_number = obj_head.pal;
                end
                default:
                begin
                    result_next.color_index    = 2'd0;
                    result_next.palette_number = 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    // pack the result word
    assign m_axis_tdata = {7'd0,
                           result_reg.obj_level,
                           result_reg.bg_level,
                           result_reg.push_accepted,
                           result_reg.palette_number,
                           result_reg.color_index,
                           result_reg.source,
                           result_reg.pixel_valid};

    `PFSM_ASSERT(a_held_item_kept,
                 in_valid_reg && !fire |=> in_valid_reg && $stable(item_reg),
                 "pending word lost")
    `PFSM_NEVER(a_src_needs_pixel,
                out_valid_reg && (result_reg.source != pfsm_pkg::SRC_NONE)
                && !result_reg.pixel_valid,
                "source without pixel")
    `PFSM_NEVER(a_push_fills_bg,
                out_valid_reg && result_reg.push_accepted
                && (result_reg.bg_level != pfsm_pkg::QFULL),
                "push left bg queue short")

endmodule

FILE: hdl/pfsm_cfg_regs.sv
// apb register file for the mixer mode bits
// depends on pfsm_pkg
module pfsm_cfg_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output pfsm_pkg::cfg_t    cfg
);

    pfsm_pkg::cfg_t cfg_reg;
    pfsm_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                pfsm_pkg::REG_COLOR_MODE: cfg_next.color_mode = pwdata[0];
                pfsm_pkg::REG_BG_ENABLE:  cfg_next.bg_enable  = pwdata[0];
                pfsm_pkg::REG_SPRITE_EN:  cfg_next.sprite_en  = pwdata[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_mode <= 1'b0;
            cfg_reg.bg_enable  <= 1'b1;
            cfg_reg.sprite_en  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (paddr[3:2])
            pfsm_pkg::REG_COLOR_MODE: prdata = {31'd0, cfg_reg.color_mode};
            pfsm_pkg::REG_BG_ENABLE:  prdata = {31'd0, cfg_reg.bg_enable};
            pfsm_pkg::REG_SPRITE_EN:  prdata = {31'd0, cfg_reg.sprite_en};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

FILE: hdl/pfsm_bg_queue.sv
// background pixel queue: shift register with the head in slot 0
// depends on pfsm_pkg and assert_macros.svh
`include "assert_macros.svh"

module pfsm_bg_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  pfsm_pkg::item_t      item,
    input  pfsm_pkg::cfg_t       cfg,
    output pfsm_pkg::bg_entry_t  head,
    output logic                 nonempty,
    output logic                 push_ok,
    output logic [3:0]           level_next
);

    pfsm_pkg::bg_entry_t [pfsm_pkg::QDEPTH-1:0] entries_reg;
    pfsm_pkg::bg_entry_t [pfsm_pkg::QDEPTH-1:0] entries_next;
    logic [3:0] count_reg;
    logic [3:0] count_next;
    logic [2:0] drop;
    logic [2:0] bit_sel;
    logic       mirror;

    assign head       = entries_reg[0];
    assign nonempty   = (count_reg != 4'd0);
    assign level_next = count_next;
    assign mirror     = cfg.color_mode && item.attr[pfsm_pkg::ATTR_FLIP_BIT];
    // discard stops at an empty queue
    assign drop = ({1'b0, item.discard_count} > count_reg) ? count_reg[2:0]
                                                           : item.discard_count;

    // next queue contents for one operation
    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        push_ok      = 1'b0;
        bit_sel      = 3'd0;
        case (item.func)
            pfsm_pkg::FUNC_CLEAR_ALL,
            pfsm_pkg::FUNC_CLEAR_BG:
            begin
                count_next = 4'd0;
            end
            pfsm_pkg::FUNC_PUSH:
            begin
                if (count_reg == 4'd0)
                begin
                    for (int k = 0; k < pfsm_pkg::QDEPTH; k++)
                    begin
                        bit_sel = mirror ? 3'(k) : 3'(7 - k);
                        entries_next[k].color = {item.plane_high[bit_sel],
                                                 item.plane_low[bit_sel]};
                        entries_next[k].pal   = cfg.color_mode ? item.attr[2:0] : 3'd0;
                        entries_next[k].prio  = cfg.color_mode &&
                                                item.attr[pfsm_pkg::ATTR_PRIO_BIT];
                    end
                    count_next = pfsm_pkg::QFULL;
                    push_ok    = 1'b1;
                end
            end
            pfsm_pkg::FUNC_DISCARD:
            begin
                entries_next = entries_reg >> (pfsm_pkg::BG_ENTRY_W * drop);
                count_next   = count_reg - {1'b0, drop};
            end
            pfsm_pkg::FUNC_POP:
            begin
                if (count_reg != 4'd0)
                begin
                    entries_next = entries_reg >> pfsm_pkg::BG_ENTRY_W;
                    count_next   = count_reg - 4'd1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 4'd0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
        end
    end

    // pixel storage, no reset
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            entries_reg <= entries_next;
        end
    end

    `PFSM_NEVER(a_bg_count_range, count_reg > pfsm_pkg::QFULL, "bg queue over depth")

endmodule

FILE: hdl/pfsm_obj_queue.sv
// object pixel queue with sprite row merge, head in slot 0
// depends on pfsm_pkg and assert_macros.svh
`include "assert_macros.svh"

module pfsm_obj_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  pfsm_pkg::item_t       item,
    input  pfsm_pkg::cfg_t        cfg,
    input  logic                  pop_en,
    output pfsm_pkg::obj_entry_t  head,
    output logic                  nonempty,
    output logic [3:0]            level_next
);

    pfsm_pkg::obj_entry_t [pfsm_pkg::QDEPTH-1:0] entries_reg;
    pfsm_pkg::obj_entry_t [pfsm_pkg::QDEPTH-1:0] entries_next;
    logic [3:0]           count_reg;
    logic [3:0]           count_next;
    pfsm_pkg::obj_entry_t cur;
    pfsm_pkg::obj_entry_t fresh;
    logic [2:0]           bit_sel;
    logic                 flip;
    logic                 take;

    assign head       = entries_reg[0];
    assign nonempty   = (count_reg != 4'd0);
    assign level_next = count_next;
    assign flip       = item.attr[pfsm_pkg::ATTR_FLIP_BIT];

    // next queue contents for one operation
    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        cur          = '0;
        fresh        = '0;
        bit_sel      = 3'd0;
        take         = 1'b0;
        case (item.func)
            pfsm_pkg::FUNC_CLEAR_ALL:
            begin
                count_next = 4'd0;
            end
            pfsm_pkg::FUNC_MIX:
            begin
                // unfilled slots count as transparent with the empty rank
                for (int p = 0; p < pfsm_pkg::QDEPTH; p++)
                begin
                    if (4'(p) < count_reg)
                    begin
                        cur = entries_reg[p];
                    end
                    else
                    begin
                        cur      = '0;
                        cur.rank = pfsm_pkg::EMPTY_RANK;
                    end
                    bit_sel     = flip ? 3'(p) : 3'(7 - p);
                    fresh.color = {item.plane_high[bit_sel], item.plane_low[bit_sel]};
                    fresh.pal   = cfg.color_mode ? item.attr[2:0]
                                : {2'd0, item.attr[pfsm_pkg::ATTR_OPAL_BIT]};
                    fresh.prio  = item.attr[pfsm_pkg::ATTR_PRIO_BIT];
                    fresh.rank  = cfg.color_mode ? item.sprite_index : 6'd0;
                    if (cfg.color_mode)
                    begin
                        take = ((item.sprite_index < cur.rank) && (fresh.color != 2'd0))
                               || (cur.color == 2'd0);
                    end
                    else
                    begin
                        take = (cur.color == 2'd0);
                    end
                    entries_next[p] = take ? fresh : cur;
                end
                count_next = pfsm_pkg::QFULL;
            end
            pfsm_pkg::FUNC_POP:
            begin
                if (pop_en && (count_reg != 4'd0))
                begin
                    entries_next = entries_reg >> $bits(pfsm_pkg::obj_entry_t);
                    count_next   = count_reg - 4'd1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 4'd0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
        end
    end

    // pixel storage, no reset
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            entries_reg <= entries_next;
        end
    end

    `PFSM_NEVER(a_obj_count_range, count_reg > pfsm_pkg::QFULL, "obj queue over depth")
    `PFSM_ASSERT(a_obj_mix_fills, fire && (item.func == pfsm_pkg::FUNC_MIX) |=> count_reg == pfsm_pkg::QFULL, "merge left queue short")

endmodule

FILE: sim/pixel_mix_monitor.sv
`timescale 1ns / 1ps
// watches the stream and register ports of the pixel queue mixer, predicts every result word
// from its own model of the two pixel queues and compares it with the one the block returns
// depends on pfsm_pkg for the operation, source and register codes and the item and result types
module pixel_mix_monitor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // plane_low[7:0], plane_high[15:8], attr[23:16], sprite_index[29:24],
    // discard_count[32:30], zero fill [39:33]
    input  logic [39:0] s_axis_tdata,
    // func[2:0]
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_valid[0], source[2:1], color_index[4:3], palette_number[7:5],
    // push_accepted[8], bg_level[12:9], obj_level[16:13], zero fill [23:17]
    input  logic [23:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          bg_pixels,
    output int          obj_pixels
);

    // model copy of the mode bits and both queues
    pfsm_pkg::cfg_t       modes;
    pfsm_pkg::bg_entry_t  bg_queue [pfsm_pkg::QDEPTH];
    pfsm_pkg::obj_entry_t obj_queue [pfsm_pkg::QDEPTH];
    logic [2:0] bg_head, obj_head;
    logic [3:0] bg_count, obj_count;

    // result words the block still owes, oldest first
    pfsm_pkg::result_t    owed_results [$];

    int                   mismatches, checked, n_bg, n_obj;
    pfsm_pkg::item_t      word_in;
    pfsm_pkg::result_t    want, got;

    // color mode choice between a background and an object pixel
    function automatic logic [1:0] color_mode_pick(input logic oprio, input logic bprio,
                                                   input logic [1:0] bcol,
                                                   input logic [1:0] ocol);
        if (ocol == 2'd0)
            return pfsm_pkg::SRC_BG;
        if (!modes.bg_enable)
            return pfsm_pkg::SRC_OBJ;
        if (!oprio && !bprio)
            return pfsm_pkg::SRC_OBJ;
        if (bcol != 2'd0)
            return pfsm_pkg::SRC_BG;
        return pfsm_pkg::SRC_OBJ;
    endfunction

    // one queue operation: updates the model and gives the result word
    task automatic apply_op(input pfsm_pkg::item_t it, output pfsm_pkg::result_t r);
        pfsm_pkg::bg_entry_t  be;
        pfsm_pkg::obj_entry_t oe, cur;
        logic [1:0] c, bcol, ocol, pick;
        logic [2:0] bpal, opal, epal, mpal, slot;
        logic       bprio, oprio, eprio, mprio, mirror, has_bg, obj_here, has_sp, take;
        int         k, sel, pos;
        r = '0;
        case (it.func)
            pfsm_pkg::FUNC_CLEAR_ALL:
            begin
                bg_head = '0;
                bg_count = '0;
                obj_head = '0;
                obj_count = '0;
            end
            pfsm_pkg::FUNC_CLEAR_BG:
            begin
                bg_head = '0;
                bg_count = '0;
            end
            pfsm_pkg::FUNC_PUSH:
            begin
                // a tile row only goes into an empty queue
                if (bg_count == 4'd0)
                begin
                    mirror = modes.color_mode && it.attr[pfsm_pkg::ATTR_FLIP_BIT];
                    epal = modes.color_mode ? it.attr[2:0] : 3'd0;
                    eprio = modes.color_mode && it.attr[pfsm_pkg::ATTR_PRIO_BIT];
                    for (k = 0; k < pfsm_pkg::QDEPTH; k++)
                    begin
                        sel = mirror ? k : 7 - k;
                        be.color = {it.plane_high[sel], it.plane_low[sel]};
                        be.pal = epal;
                        be.prio = eprio;
                        bg_queue[3'(bg_head + k)] = be;
                    end
                    bg_count = pfsm_pkg::QFULL;
                    r.push_accepted = 1'b1;
                end
            end
            pfsm_pkg::FUNC_DISCARD:
            begin
                for (k = 0; k < it.discard_count && bg_count != 4'd0; k++)
                begin
                    bg_head = bg_head + 3'd1;
                    bg_count = bg_count - 4'd1;
                end
            end
            pfsm_pkg::FUNC_MIX:
            begin
                mpal = modes.color_mode ? it.attr[2:0]
                                        : {2'b00, it.attr[pfsm_pkg::ATTR_OPAL_BIT]};
                mprio = it.attr[pfsm_pkg::ATTR_PRIO_BIT];
                // pad the object queue with transparent slots of the empty rank
                while (obj_count < pfsm_pkg::QFULL)
                begin
                    oe = '0;
                    oe.rank = pfsm_pkg::EMPTY_RANK;
                    obj_queue[3'(obj_head + obj_count)] = oe;
                    obj_count = obj_count + 4'd1;
                end
                for (k = 0; k < pfsm_pkg::QDEPTH; k++)
                begin
                    pos = it.attr[pfsm_pkg::ATTR_FLIP_BIT] ? 7 - k : k;
                    slot = 3'(pos + obj_head);
                    c = {it.plane_high[7 - k], it.plane_low[7 - k]};
                    cur = obj_queue[slot];
                    if (!modes.color_mode)
                        take = (cur.color == 2'd0);
                    else
                        take = ((it.sprite_index < cur.rank) && c != 2'd0) ||
                               (cur.color == 2'd0);
                    if (take)
                    begin
                        oe.color = c;
                        oe.pal = mpal;
                        oe.prio = mprio;
                        oe.rank = modes.color_mode ? it.sprite_index : 6'd0;
                        obj_queue[slot] = oe;
                    end
                end
            end
            pfsm_pkg::FUNC_POP:
            begin
                if (bg_count != 4'd0)
                begin
                    be = bg_queue[bg_head];
                    bcol = be.color;
                    bpal = modes.color_mode ? be.pal : 3'd0;
                    bprio = be.prio;
                    has_bg = modes.color_mode || modes.bg_enable;
                    obj_here = 1'b0;
                    ocol = '0;
                    opal = '0;
                    oprio = 1'b0;
                    bg_head = bg_head + 3'd1;
                    bg_count = bg_count - 4'd1;
                    r.pixel_valid = 1'b1;
                    if (obj_count != 4'd0)
                    begin
                        oe = obj_queue[obj_head];
                        ocol = oe.color;
                        opal = oe.pal;
                        oprio = oe.prio;
                        obj_here = 1'b1;
                        obj_head = obj_head + 3'd1;
                        obj_count = obj_count - 4'd1;
                    end
                    has_sp = modes.sprite_en && obj_here;
                    // priority between the two pixels
                    if (has_bg && !has_sp)
                        pick = pfsm_pkg::SRC_BG;
                    else if (!has_bg && has_sp)
                        pick = pfsm_pkg::SRC_OBJ;
                    else if (has_bg && has_sp)
                    begin
                        if (modes.color_mode)
                            pick = color_mode_pick(oprio, bprio, bcol, ocol);
                        else if (oprio && bcol != 2'd0)
                            pick = pfsm_pkg::SRC_BG;
                        else if (ocol == 2'd0)
                            pick = pfsm_pkg::SRC_BG;
                        else
                            pick = pfsm_pkg::SRC_OBJ;
                    end
                    else
                        pick = pfsm_pkg::SRC_NONE;
                    r.source = pick;
                    if (pick == pfsm_pkg::SRC_BG)
                    begin
                        r.color_index = bcol;
                        r.palette_number = bpal;
                    end
                    else if (pick == pfsm_pkg::SRC_OBJ)
                    begin
                        r.color_index = ocol;
                        r.palette_number = opal;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.bg_level = bg_count;
        r.obj_level = obj_count;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes.color_mode = 1'b0;
            modes.bg_enable = 1'b1;
            modes.sprite_en = 1'b0;
            for (int i = 0; i < pfsm_pkg::QDEPTH; i++)
            begin
                bg_queue[i] = '0;
                obj_queue[i] = '0;
            end
            bg_head = '0;
            obj_head = '0;
            bg_count = '0;
            obj_count = '0;
            owed_results.delete();
            mismatches = 0;
            checked = 0;
            n_bg = 0;
            n_obj = 0;
            fail_count <= 0;
            pending <= 0;
            results_seen <= 0;
            bg_pixels <= 0;
            obj_pixels <= 0;
        end
        else
        begin
            // mode register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    pfsm_pkg::REG_COLOR_MODE: modes.color_mode = pwdata[0];
                    pfsm_pkg::REG_BG_ENABLE:  modes.bg_enable = pwdata[0];
                    pfsm_pkg::REG_SPRITE_EN:  modes.sprite_en = pwdata[0];
                    default:
                    begin
                    end
                endcase
            end

            // result word against the oldest owed one
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.pixel_valid = m_axis_tdata[0];
                got.source = m_axis_tdata[2:1];
                got.color_index = m_axis_tdata[4:3];
                got.palette_number = m_axis_tdata[7:5];
                got.push_accepted = m_axis_tdata[8];
                got.bg_level = m_axis_tdata[12:9];
                got.obj_level = m_axis_tdata[16:13];
                checked++;
                if (owed_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result word %h", $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got.pixel_valid !== want.pixel_valid ||
                        got.source !== want.source ||
                        got.color_index !== want.color_index ||
                        got.palette_number !== want.palette_number ||
                        got.push_accepted !== want.push_accepted ||
                        got.bg_level !== want.bg_level ||
                        got.obj_level !== want.obj_level)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: mismatch valid/src/col/pal/push/bg/obj", $time);
                            $display("  expected %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                                     want.pixel_valid, want.source, want.color_index,
                                     want.palette_number, want.push_accepted,
                                     want.bg_level, want.obj_level);
                            $display("  got      %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                                     got.pixel_valid, got.source, got.color_index,
                                     got.palette_number, got.push_accepted,
                                     got.bg_level, got.obj_level);
                        end
                        mismatches++;
                    end
                    if (want.source == pfsm_pkg::SRC_BG)
                        n_bg++;
                    else if (want.source == pfsm_pkg::SRC_OBJ)
                        n_obj++;
                end
            end

            // accepted input word
            if (s_axis_tvalid && s_axis_tready)
            begin
                word_in.func = s_axis_tuser;
                word_in.plane_low = s_axis_tdata[7:0];
                word_in.plane_high = s_axis_tdata[15:8];
                word_in.attr = s_axis_tdata[23:16];
                word_in.sprite_index = s_axis_tdata[29:24];
                word_in.discard_count = s_axis_tdata[32:30];
                apply_op(word_in, want);
                owed_results.push_back(want);
            end

            fail_count <= mismatches;
            pending <= owed_results.size();
            results_seen <= checked;
            bg_pixels <= n_bg;
            obj_pixels <= n_obj;
        end
    end

endmodule

FILE: sim/tb_pixel_fifo_sprite_mixer_core.sv
`timescale 1ns / 1ps
// top of the pixel queue mixer testbench: clock, reset, mode writes, queue operation words
// and result back pressure; depends on pfsm_pkg, pixel_mix_monitor and the block itself
module tb_pixel_fifo_sprite_mixer_core;

    // unused operation codes, expected to leave the queues alone
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;
    localparam int         HOLD_LEN    = 300;
    localparam int         ITEMS_PER_PHASE = 153;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count, pending, results_seen, bg_pixels, obj_pixels;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          items_sent = 0;
    int          hold_cycles = 0;
    logic        hold_req = 1'b0;

    // mode settings per phase as {color_mode, bg_enable, sprite_en}
    logic [2:0]  phase_modes [8] = '{3'b011, 3'b111, 3'b101, 3'b001,
                                     3'b110, 3'b010, 3'b000, 3'b100};

    pixel_fifo_sprite_mixer_core dut (.*);

    pixel_mix_monitor u_mix_monitor (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && hold_cycles < HOLD_LEN)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // one operation word, after a random number of idle cycles
    task automatic send_op(input logic [2:0] func, input logic [7:0] lo, input logic [7:0] hi,
                           input logic [7:0] at, input logic [5:0] idx,
                           input logic [2:0] drop);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= {7'd0, drop, idx, at, hi, lo};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    function automatic logic [5:0] rand_index();
        return ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63))
                                            : 6'($urandom_range(0, 39));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [2:0] rand_drop();
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic logic [2:0] rand_func();
        return 3'($urandom_range(0, 7));
    endfunction

    // access phase ends with psel still high, the caller drops it
    task automatic reg_write(input logic [1:0] idx, input logic value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {31'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    // wait for the block to drain, then write all three mode bits
    task automatic set_modes(input logic [2:0] m);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        reg_write(pfsm_pkg::REG_COLOR_MODE, m[2]);
        reg_write(pfsm_pkg::REG_BG_ENABLE, m[1]);
        reg_write(pfsm_pkg::REG_SPRITE_EN, m[0]);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // mostly scanline-like rows: push, fine scroll, sprites, drain; the rest is noise
    task automatic run_random(input int n);
        int start;
        start = items_sent;
        while (items_sent - start < n)
        begin
            if ($urandom_range(0, 99) < 65)
            begin
                send_op(pfsm_pkg::FUNC_PUSH, rand_byte(), rand_byte(), rand_byte(),
                        rand_index(), rand_drop());
                if ($urandom_range(0, 3) == 0)
                    send_op(pfsm_pkg::FUNC_DISCARD, rand_byte(), rand_byte(), rand_byte(),
                            rand_index(), rand_drop());
                repeat ($urandom_range(0, 3))
                    send_op(pfsm_pkg::FUNC_MIX, rand_byte(), rand_byte(), rand_byte(),
                            rand_index(), rand_drop());
                repeat ($urandom_range(5, 9))
                    send_op(pfsm_pkg::FUNC_POP, rand_byte(), rand_byte(), rand_byte(),
                            rand_index(), rand_drop());
            end
            else
                send_op(rand_func(), rand_byte(), rand_byte(), rand_byte(),
                        rand_index(), rand_drop());
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // compatibility mode at reset values: empty pop, push into a full queue refused, scroll past the end
        send_op(pfsm_pkg::FUNC_POP, 8'h00, 8'h00, 8'h00, 6'd0, 3'd0);
        send_op(pfsm_pkg::FUNC_PUSH, 8'hFF, 8'h00, 8'hFF, 6'd63, 3'd7);
        send_op(pfsm_pkg::FUNC_PUSH, 8'h00, 8'hFF, 8'h00, 6'd0, 3'd0);
        send_op(pfsm_pkg::FUNC_DISCARD, 8'h00, 8'h00, 8'h00, 6'd0, 3'd7);
        send_op(pfsm_pkg::FUNC_DISCARD, 8'h00, 8'h00, 8'h00, 6'd0, 3'd7);
        send_op(FUNC_SPARE6, 8'hFF, 8'hFF, 8'hFF, 6'd63, 3'd7);
        send_op(FUNC_SPARE7, 8'hFF, 8'hFF, 8'hFF, 6'd63, 3'd7);
        send_op(pfsm_pkg::FUNC_PUSH, 8'hA5, 8'h3C, 8'h20, 6'd0, 3'd0);
        send_op(pfsm_pkg::FUNC_MIX, 8'hFF, 8'hFF, 8'hB0, 6'd0, 3'd0);
        send_op(pfsm_pkg::FUNC_MIX, 8'h0F, 8'hF0, 8'h20, 6'd39, 3'd0);
        repeat (3) send_op(pfsm_pkg::FUNC_POP, 8'h00, 8'h00, 8'h00, 6'd0, 3'd0);

        // background off with objects present, then both clears
        set_modes(3'b001);
        send_op(pfsm_pkg::FUNC_POP, 8'h00, 8'h00, 8'h00, 6'd0, 3'd0);
        send_op(pfsm_pkg::FUNC_CLEAR_BG, 8'h00, 8'h00, 8'h00, 6'd0, 3'd0);
        send_op(pfsm_pkg::FUNC_POP, 8'h00, 8'h00, 8'h00, 6'd0, 3'd0);
        send_op(pfsm_pkg::FUNC_CLEAR_ALL, 8'h00, 8'h00, 8'h00, 6'd0, 3'd0);

        // color mode: flipped row with priority and palette, high object indexes
        set_modes(3'b111);
        send_op(pfsm_pkg::FUNC_PUSH, 8'h0F, 8'h33, 8'hA7, 6'd0, 3'd0);
        send_op(pfsm_pkg::FUNC_MIX, 8'hF0, 8'h00, 8'h03, 6'd63, 3'd0);
        send_op(pfsm_pkg::FUNC_MIX, 8'hFF, 8'h00, 8'h05, 6'd60, 3'd0);
        send_op(pfsm_pkg::FUNC_MIX, 8'hAA, 8'h55, 8'h81, 6'd0, 3'd0);
        repeat (4) send_op(pfsm_pkg::FUNC_POP, 8'h00, 8'h00, 8'h00, 6'd0, 3'd0);
        send_op(pfsm_pkg::FUNC_DISCARD, 8'h00, 8'h00, 8'h00, 6'd0, 3'd0);
        send_op(pfsm_pkg::FUNC_POP, 8'h00, 8'h00, 8'h00, 6'd0, 3'd0);

        // random phases over all mode settings and idle patterns
        for (int p = 0; p < 8; p++)
        begin
            set_modes(phase_modes[p]);
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 80;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 80;
                end
                default:
                begin
                    idle_pct = 26;
                    stall_pct = 26;
                end
            endcase
            if (p == 0)
                hold_req = 1'b1;
            run_random(ITEMS_PER_PHASE);
        end

        // drain
        s_axis_tvalid <= 1'b0;
        stall_pct = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("run: %0d operation words over 8 mode settings, %0d result words compared",
                 items_sent, results_seen);
        $display("run: %0d background and %0d object pixels shown", bg_pixels, obj_pixels);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
